>>> design/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg: shared types and constants of the blob frame deframer
// Configuration register indexes, reset values and the report struct that
// travels from the parser to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

  localparam int ByteW  = 8;
  localparam int CntW   = 4;   // frame byte count, covers limits up to 15
  localparam int HistD  = 5;   // stored bytes kept for the report
  localparam int CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFirstHeader  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondHeader = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEndMarker    = 2'd2;

  localparam logic [ByteW-1:0] FirstHeaderRst  = 8'h2C;
  localparam logic [ByteW-1:0] SecondHeaderRst = 8'h12;
  localparam logic [ByteW-1:0] EndMarkerRst    = 8'h5B;

  typedef struct packed {
    logic [ByteW-1:0] end_marker;
    logic [ByteW-1:0] second_header;
    logic [ByteW-1:0] first_header;
  } bfd_cfg_t;

  typedef struct packed {
    logic             ended_by_marker;
    logic [ByteW-1:0] blob_h;
    logic [ByteW-1:0] blob_w;
    logic [ByteW-1:0] blob_y;
    logic [ByteW-1:0] blob_x;
  } bfd_rpt_t;

endpackage

`default_nettype wire

>>> design/blob_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// blob_frame_deframer_top: blob report deframer
// Pulls blob reports out of a framed serial byte stream.
// ----------------------------------------------------------------------------
// The block takes one received byte per transaction on in_ and hunts for the
// first header byte, then the second header byte, then collects body bytes
// until the end marker arrives or the frame holds MAX_FRAME bytes (headers
// included). Each finished frame yields one transaction on out_ with x, y,
// width and height (the four bytes stored before the last one, zero where the
// frame is shorter) and a tuser flag that is set when the end marker closed
// the frame. The byte after a frame is always consumed and the parser returns
// to the hunt. A byte is taken in every cycle: the parser updates in a single
// pass and its report lands in one output register, so in_tready drops only
// while a report sits there with out_tready low. The user must write header and
// marker bytes via cfg_ at indexes 0, 1, 2 only with the stream idle; unchecked.
`default_nettype none

module blob_frame_deframer_top #(
  parameter int MAX_FRAME = 10   // 6 to 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] rx_byte
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [7:0] blob_x, [15:8] blob_y, [23:16] blob_w, [31:24] blob_h
  output logic [31:0]                      out_tdata,
  output logic                             out_tuser,  // [0] ended_by_marker
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bfd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [7:0]                  cfg_data
);
  import bfd_pkg::*;

  bfd_cfg_t cfg_r;
  logic     in_acc;
  logic     rpt_valid;
  bfd_rpt_t rpt;
  bfd_rpt_t out_r;
  logic     out_valid_r, out_valid_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_header  <= FirstHeaderRst;
      cfg_r.second_header <= SecondHeaderRst;
      cfg_r.end_marker    <= EndMarkerRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgFirstHeader:  cfg_r.first_header  <= cfg_data;
        CfgSecondHeader: cfg_r.second_header <= cfg_data;
        CfgEndMarker:    cfg_r.end_marker    <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  bfd_parser #(.MAX_FRAME(MAX_FRAME)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .rx_byte   (in_tdata),
    .cfg       (cfg_r),
    .rpt_valid (rpt_valid),
    .rpt       (rpt)
  );

  always_comb begin
    if (in_acc) out_valid_nxt = rpt_valid;
    else        out_valid_nxt = out_valid_r && !out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && rpt_valid) begin
      out_r <= rpt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.blob_h, out_r.blob_w, out_r.blob_y, out_r.blob_x};
  assign out_tuser  = out_r.ended_by_marker;

endmodule

`default_nettype wire

>>> design/bfd_parser.sv
// ----------------------------------------------------------------------------
// bfd_parser: frame hunt and body collection
// Tracks the parse phase, the frame byte count and the last stored bytes.
// On each accepted byte it updates state and flags a report when a frame ends.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_parser #(
  parameter int MAX_FRAME = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    step,
  input  wire logic [bfd_pkg::ByteW-1:0] rx_byte,
  input  wire bfd_pkg::bfd_cfg_t       cfg,
  output logic                         rpt_valid,
  output bfd_pkg::bfd_rpt_t            rpt
);
  import bfd_pkg::*;

  localparam logic [1:0] P_HUNT = 2'd0;
  localparam logic [1:0] P_HDR2 = 2'd1;
  localparam logic [1:0] P_BODY = 2'd2;
  localparam logic [1:0] P_DONE = 2'd3;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_FRAME);

  logic [1:0]       phase_r, phase_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [ByteW-1:0] hist_r [HistD];
  logic [ByteW-1:0] hist_nxt [HistD];
  logic             marker;

  assign cnt_inc = cnt_r + 1'b1;
  assign marker  = (rx_byte == cfg.end_marker);

  // report fields: the four bytes stored before the newest one
  assign rpt.blob_x          = hist_r[3];
  assign rpt.blob_y          = hist_r[2];
  assign rpt.blob_w          = hist_r[1];
  assign rpt.blob_h          = hist_r[0];
  assign rpt.ended_by_marker = marker;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    hist_nxt  = hist_r;
    rpt_valid = 1'b0;
    case (phase_r)
      P_HUNT: begin
        for (int i = 0; i < HistD; i++) hist_nxt[i] = '0;
        cnt_nxt = '0;
        if (rx_byte == cfg.first_header) begin
          hist_nxt[0] = rx_byte;
          cnt_nxt     = CntW'(1);
          phase_nxt   = P_HDR2;
        end
      end
      P_HDR2: begin
        if (rx_byte == cfg.second_header) begin
          for (int i = 1; i < HistD; i++) hist_nxt[i] = hist_r[i-1];
          hist_nxt[0] = rx_byte;
          cnt_nxt     = cnt_inc;
          phase_nxt   = P_BODY;
        end else begin
          for (int i = 0; i < HistD; i++) hist_nxt[i] = '0;
          cnt_nxt   = '0;
          phase_nxt = P_HUNT;
        end
      end
      P_BODY: begin
        for (int i = 1; i < HistD; i++) hist_nxt[i] = hist_r[i-1];
        hist_nxt[0] = rx_byte;
        cnt_nxt     = cnt_inc;
        if (cnt_inc >= MaxCnt || marker) begin
          phase_nxt = P_DONE;
          rpt_valid = 1'b1;
        end
      end
      default: begin
        // consume the trailing byte; keep history only on a marker ending
        if (hist_r[0] != cfg.end_marker) begin
          for (int i = 0; i < HistD; i++) hist_nxt[i] = '0;
        end
        cnt_nxt   = '0;
        phase_nxt = P_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_HUNT;
      cnt_r   <= '0;
      for (int i = 0; i < HistD; i++) hist_r[i] <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      hist_r  <= hist_nxt;
    end
  end

  a_rpt_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    step && rpt_valid |=> phase_r == P_DONE)
    else $error("report without move to frame done");

  a_body_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == P_BODY |-> cnt_r < MaxCnt)
    else $error("body phase with count at limit");

  a_done_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == P_DONE |=> phase_r == P_HUNT && cnt_r == '0)
    else $error("trailing byte did not return to hunt");

  a_hdr2_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == P_HDR2 |-> cnt_r == CntW'(1))
    else $error("second header wait with wrong count");

endmodule

`default_nettype wire
